// ===== rtl/dlb_pkg.sv =====
// Shared types, codes and fixed widths for the dense layer backward pass.
`timescale 1ns / 1ps
package dlb_pkg;

  // Element format: signed Q4.12
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  // Field widths of the channels
  localparam int MODE_W    = 2;
  localparam int IDX_W     = 6;
  localparam int COUNT_W   = 7;
  localparam int CFG_IDX_W = 2;

  // Item operation codes
  localparam logic [MODE_W-1:0] MODE_LOAD_GRAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_ACT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_WGT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_START     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_APPLY_DERIV  = 2'd2;

  // Operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_GW    = 2'd0,   // gradient times weight
    MUL_DERIV = 2'd1,   // y times (1 - y)
    MUL_SCALE = 2'd2    // rounded sum times derivative
  } mul_sel_t;

  typedef struct packed {
    logic [COUNT_W-1:0] output_count;
    logic [COUNT_W-1:0] input_count;
    logic               apply_derivative;
  } dlb_cfg_t;

  // Datapath controls from the sequencer
  typedef struct packed {
    mul_sel_t mul_sel;
    logic     mul_en;
    logic     acc_clr;
    logic     acc_en;
    logic     rnd_acc;
    logic     val_en;
    logic     deriv_en;
  } dlb_ctrl_t;

  // Result request from the sequencer
  typedef struct packed {
    logic             load;
    logic             last;
    logic [IDX_W-1:0] column;
  } dlb_emit_t;

endpackage

// ===== rtl/dlb_if.sv =====
// Channel interfaces: load/start items, result items and configuration writes.
`timescale 1ns / 1ps
interface dlb_item_if;
  import dlb_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [MODE_W-1:0]            mode;
  logic [IDX_W-1:0]             row;
  logic [IDX_W-1:0]             col;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink (input valid, mode, row, col, value, output ready);
endinterface

interface dlb_result_if;
  import dlb_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [IDX_W-1:0]             column;
  logic signed [DATA_WIDTH-1:0] back_gradient;
  logic                         saturated;
  logic                         last;

  modport source (output valid, column, back_gradient, saturated, last, input ready);
  modport sink (input valid, column, back_gradient, saturated, last, output ready);
endinterface

interface dlb_cfg_if;
  import dlb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COUNT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/dlb_store.sv =====
// Gradient, activation and weight memories with registered read ports.
`timescale 1ns / 1ps
module dlb_store #(
  parameter int MAX_OUTPUTS = 64,
  parameter int MAX_INPUTS  = 64,
  parameter int RA_W        = 6,
  parameter int CA_W        = 6
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [dlb_pkg::MODE_W-1:0]            mode,
  input  logic [dlb_pkg::IDX_W-1:0]             row,
  input  logic [dlb_pkg::IDX_W-1:0]             col,
  input  logic signed [dlb_pkg::DATA_WIDTH-1:0] value,
  input  logic [RA_W-1:0]                       rd_row,
  input  logic [CA_W-1:0]                       rd_col,
  output logic signed [dlb_pkg::DATA_WIDTH-1:0] grad_q,
  output logic signed [dlb_pkg::DATA_WIDTH-1:0] wgt_q,
  output logic signed [dlb_pkg::DATA_WIDTH-1:0] act_q
);
  import dlb_pkg::*;

  localparam int DEPTH = MAX_OUTPUTS * MAX_INPUTS;
  localparam int WA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [DATA_WIDTH-1:0] grad_mem [MAX_OUTPUTS];
  logic signed [DATA_WIDTH-1:0] act_mem  [MAX_INPUTS];
  logic signed [DATA_WIDTH-1:0] wgt_mem  [DEPTH];

  logic            row_ok;
  logic            col_ok;
  logic [WA_W-1:0] wr_addr;
  logic [WA_W-1:0] rd_addr;

  // Drop loads whose index falls outside the stores
  assign row_ok = COUNT_W'(row) < COUNT_W'(MAX_OUTPUTS);
  assign col_ok = COUNT_W'(col) < COUNT_W'(MAX_INPUTS);

  // Weights are laid out row by row
  assign wr_addr = WA_W'(int'(row) * MAX_INPUTS + int'(col));
  assign rd_addr = WA_W'(int'(rd_row) * MAX_INPUTS + int'(rd_col));

  // Write on load transfers
  always_ff @(posedge clk) begin
    if (wr_en && mode == MODE_LOAD_GRAD && row_ok) begin
      grad_mem[row[RA_W-1:0]] <= value;
    end
    if (wr_en && mode == MODE_LOAD_ACT && col_ok) begin
      act_mem[col[CA_W-1:0]] <= value;
    end
    if (wr_en && mode == MODE_LOAD_WGT && row_ok && col_ok) begin
      wgt_mem[wr_addr] <= value;
    end
  end

  // Read continuously at the sequencer's addresses
  always_ff @(posedge clk) begin
    grad_q <= grad_mem[rd_row];
    wgt_q  <= wgt_mem[rd_addr];
    act_q  <= act_mem[rd_col];
  end

endmodule

// ===== rtl/dlb_mac.sv =====
// Shared multiplier, accumulator, Q.12 rounder and output saturation.
`timescale 1ns / 1ps
module dlb_mac #(
  parameter int MAX_OUTPUTS = 64
) (
  input  logic                                  clk,
  input  dlb_pkg::dlb_ctrl_t                    ctrl,
  input  logic signed [dlb_pkg::DATA_WIDTH-1:0] grad,
  input  logic signed [dlb_pkg::DATA_WIDTH-1:0] wgt,
  input  logic signed [dlb_pkg::DATA_WIDTH-1:0] act,
  output logic signed [dlb_pkg::DATA_WIDTH-1:0] sat_value,
  output logic                                  sat_flag
);
  import dlb_pkg::*;

  // Exact sum of products, its rounded form, the derivative, the final product
  localparam int ACC_W  = 2 * DATA_WIDTH + $clog2(MAX_OUTPUTS);
  localparam int A_W    = ACC_W - FRAC_BITS;
  localparam int B_W    = 2 * DATA_WIDTH + 1 - FRAC_BITS;
  localparam int PROD_W = A_W + B_W;
  localparam int VAL_W  = PROD_W - FRAC_BITS;

  localparam logic signed [DATA_WIDTH:0]   ONE_Q   = (DATA_WIDTH + 1)'(1 << FRAC_BITS);
  localparam logic signed [PROD_W-1:0]     HALF_Q  = PROD_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [VAL_W-1:0]      SAT_MAX = VAL_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [VAL_W-1:0]      SAT_MIN = ~SAT_MAX;

  logic signed [DATA_WIDTH:0] one_minus_y;
  logic signed [A_W-1:0]      mul_a;
  logic signed [B_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [PROD_W-1:0]   rnd_in;
  logic signed [PROD_W-1:0]   rnd_sum;
  logic signed [VAL_W-1:0]    rnd_out;
  logic signed [VAL_W-1:0]    val;
  logic signed [B_W-1:0]      deriv;

  assign one_minus_y = ONE_Q - (DATA_WIDTH + 1)'(act);

  // Select multiplier operands
  always_comb begin
    case (ctrl.mul_sel)
      MUL_GW: begin
        mul_a = A_W'(grad);
        mul_b = B_W'(wgt);
      end
      MUL_DERIV: begin
        mul_a = A_W'(act);
        mul_b = B_W'(one_minus_y);
      end
      MUL_SCALE: begin
        mul_a = $signed(val[A_W-1:0]);
        mul_b = deriv;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Register each product
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Accumulate products exactly
  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Round half up and drop the fraction bits
  assign rnd_in  = ctrl.rnd_acc ? PROD_W'(acc) : prod;
  assign rnd_sum = rnd_in + HALF_Q;
  assign rnd_out = VAL_W'(rnd_sum >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (ctrl.val_en) begin
      val <= rnd_out;
    end
    if (ctrl.deriv_en) begin
      deriv <= $signed(rnd_out[B_W-1:0]);
    end
  end

  // Clip to the element range
  always_comb begin
    if (val > SAT_MAX) begin
      sat_value = $signed(SAT_MAX[DATA_WIDTH-1:0]);
      sat_flag  = 1'b1;
    end else if (val < SAT_MIN) begin
      sat_value = $signed(SAT_MIN[DATA_WIDTH-1:0]);
      sat_flag  = 1'b1;
    end else begin
      sat_value = $signed(val[DATA_WIDTH-1:0]);
      sat_flag  = 1'b0;
    end
  end

endmodule

// ===== rtl/dlb_seq.sv =====
// Sequencer: walks rows and columns and steps the shared datapath.
`timescale 1ns / 1ps
module dlb_seq #(
  parameter int MAX_OUTPUTS = 64,
  parameter int MAX_INPUTS  = 64,
  parameter int RA_W        = 6,
  parameter int CA_W        = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dlb_pkg::dlb_cfg_t  cfg,
  input  logic               out_free,
  output logic               idle,
  output logic [RA_W-1:0]    rd_row,
  output logic [CA_W-1:0]    rd_col,
  output dlb_pkg::dlb_ctrl_t ctrl,
  output dlb_pkg::dlb_emit_t emit
);
  import dlb_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MAC  = 8'b0000_0010,
    S_RSUM = 8'b0000_0100,
    S_DMUL = 8'b0000_1000,
    S_DRND = 8'b0001_0000,
    S_FMUL = 8'b0010_0000,
    S_FRND = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [COUNT_W-1:0] r_cnt;
  logic [COUNT_W-1:0] r_cnt_next;
  logic [CA_W-1:0]    col;
  logic [CA_W-1:0]    col_next;
  logic               rd_vld;
  logic               prod_vld;
  logic               issue;
  logic               col_last;
  logic [COUNT_W-1:0] rows;
  logic [COUNT_W-1:0] cols;

  // Clamp counts to the store sizes
  assign rows = (cfg.output_count > COUNT_W'(MAX_OUTPUTS)) ? COUNT_W'(MAX_OUTPUTS)
                                                            : cfg.output_count;
  assign cols = (cfg.input_count > COUNT_W'(MAX_INPUTS)) ? COUNT_W'(MAX_INPUTS)
                                                          : cfg.input_count;

  assign col_last = (COUNT_W'(col) + COUNT_W'(1)) == cols;
  assign idle     = (state == S_IDLE);
  assign rd_row   = r_cnt[RA_W-1:0];
  assign rd_col   = col;

  always_comb begin
    state_next  = state;
    r_cnt_next  = r_cnt;
    col_next    = col;
    issue       = 1'b0;
    ctrl        = '0;
    ctrl.mul_sel = MUL_GW;
    emit.load   = 1'b0;
    emit.last   = col_last;
    emit.column = IDX_W'(col);
    unique case (state)
      S_IDLE: begin
        if (start && cols != '0) begin
          col_next     = '0;
          r_cnt_next   = '0;
          ctrl.acc_clr = 1'b1;
          state_next   = S_MAC;
        end
      end
      // Issue one row a cycle; products follow through the read and product registers
      S_MAC: begin
        issue       = r_cnt < rows;
        ctrl.mul_en = rd_vld;
        ctrl.acc_en = prod_vld;
        if (issue) begin
          r_cnt_next = r_cnt + COUNT_W'(1);
        end else if (!rd_vld && !prod_vld) begin
          state_next = S_RSUM;
        end
      end
      S_RSUM: begin
        ctrl.rnd_acc = 1'b1;
        ctrl.val_en  = 1'b1;
        state_next   = cfg.apply_derivative ? S_DMUL : S_EMIT;
      end
      S_DMUL: begin
        ctrl.mul_sel = MUL_DERIV;
        ctrl.mul_en  = 1'b1;
        state_next   = S_DRND;
      end
      S_DRND: begin
        ctrl.deriv_en = 1'b1;
        state_next    = S_FMUL;
      end
      S_FMUL: begin
        ctrl.mul_sel = MUL_SCALE;
        ctrl.mul_en  = 1'b1;
        state_next   = S_FRND;
      end
      S_FRND: begin
        ctrl.val_en = 1'b1;
        state_next  = S_EMIT;
      end
      // Hold the result until the output register frees up
      S_EMIT: begin
        if (out_free) begin
          emit.load = 1'b1;
          if (col_last) begin
            state_next = S_IDLE;
          end else begin
            col_next     = col + CA_W'(1);
            r_cnt_next   = '0;
            ctrl.acc_clr = 1'b1;
            state_next   = S_MAC;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      r_cnt    <= '0;
      col      <= '0;
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      state    <= state_next;
      r_cnt    <= r_cnt_next;
      col      <= col_next;
      rd_vld   <= issue;
      prod_vld <= rd_vld;
    end
  end

endmodule

// ===== rtl/dense_layer_backprop.sv =====
// Top level of the fixed-point dense layer backward pass.
`timescale 1ns / 1ps
// Usage:
//   cfg    : register writes (0 output_count, 1 input_count, 2 apply_derivative),
//            always ready; write only while the block is idle.
//   item   : mode 0/1/2 loads a gradient, activation or weight element; mode 3
//            starts a run. Loads are accepted back to back.
//   result : one transfer per input column, in column order, last flagged on
//            the final column. A run with input_count of zero gives nothing.
// Course of a run: per column, the single shared multiplier takes one row per cycle
//   of output_count clamped to MAX_OUTPUTS, behind a read and product register,
//   then the rounding step, and with the derivative on the derivative and
//   scaling steps, run in turn. item.ready is low for the whole run.
// A stalled receiver holds the finished result in the output register and the
//   sequencer waits in its emit step; nothing is lost or repeated.
// Reset clears the registers to 1, 1, 1 and the handshake state; the stores
//   hold no reset value and must be loaded before use.
module dense_layer_backprop #(
  parameter int MAX_OUTPUTS = 64,
  parameter int MAX_INPUTS  = 64
) (
  input logic          clk,
  input logic          rst,
  dlb_cfg_if.sink      cfg,
  dlb_item_if.sink     item,
  dlb_result_if.source result
);
  import dlb_pkg::*;

  localparam int RA_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int CA_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  dlb_cfg_t                 cfg_q;
  dlb_ctrl_t                ctrl;
  dlb_emit_t                emit;
  logic                     idle;
  logic                     item_xfer;
  logic                     start;
  logic                     out_free;
  logic [RA_W-1:0]          rd_row;
  logic [CA_W-1:0]          rd_col;
  logic signed [DATA_WIDTH-1:0] grad_q;
  logic signed [DATA_WIDTH-1:0] wgt_q;
  logic signed [DATA_WIDTH-1:0] act_q;
  logic signed [DATA_WIDTH-1:0] sat_value;
  logic                     sat_flag;
  logic                     out_valid;
  logic [IDX_W-1:0]         out_column;
  logic signed [DATA_WIDTH-1:0] out_gradient;
  logic                     out_saturated;
  logic                     out_last;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.output_count     <= COUNT_W'(1);
      cfg_q.input_count      <= COUNT_W'(1);
      cfg_q.apply_derivative <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_OUTPUT_COUNT: cfg_q.output_count     <= cfg.data;
        CFG_INPUT_COUNT:  cfg_q.input_count      <= cfg.data;
        CFG_APPLY_DERIV:  cfg_q.apply_derivative <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Item handshake
  assign item.ready = idle;
  assign item_xfer  = item.valid && idle;
  assign start      = item_xfer && item.mode == MODE_START;

  dlb_store #(
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .MAX_INPUTS  (MAX_INPUTS),
    .RA_W        (RA_W),
    .CA_W        (CA_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (item_xfer),
    .mode   (item.mode),
    .row    (item.row),
    .col    (item.col),
    .value  (item.value),
    .rd_row (rd_row),
    .rd_col (rd_col),
    .grad_q (grad_q),
    .wgt_q  (wgt_q),
    .act_q  (act_q)
  );

  dlb_seq #(
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .MAX_INPUTS  (MAX_INPUTS),
    .RA_W        (RA_W),
    .CA_W        (CA_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cfg      (cfg_q),
    .out_free (out_free),
    .idle     (idle),
    .rd_row   (rd_row),
    .rd_col   (rd_col),
    .ctrl     (ctrl),
    .emit     (emit)
  );

  dlb_mac #(
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_mac (
    .clk       (clk),
    .ctrl      (ctrl),
    .grad      (grad_q),
    .wgt       (wgt_q),
    .act       (act_q),
    .sat_value (sat_value),
    .sat_flag  (sat_flag)
  );

  // Output register: load on emit, drop on transfer
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_column    <= emit.column;
      out_gradient  <= sat_value;
      out_saturated <= sat_flag;
      out_last      <= emit.last;
    end
  end

  assign result.valid         = out_valid;
  assign result.column        = out_column;
  assign result.back_gradient = out_gradient;
  assign result.saturated     = out_saturated;
  assign result.last          = out_last;

endmodule
